// ----- rtl/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the closest pair sum search block.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;
    localparam int SUM_W         = DATA_W + 1;
    localparam int DIFF_W        = DATA_W + 2;

    typedef struct packed {
        logic take;     // input request accepted
        logic ins_rd;   // insertion: read neighbor or place at head
        logic ins_cmp;  // insertion: compare and shift or place
        logic fin;      // set complete: start scan or flag invalid
        logic sc_rd;    // scan: read both ends
        logic sc_diff;  // scan: sum minus target
        logic sc_eval;  // scan: keep best, step pointers
        logic out_ack;  // result request taken
    } t_cmd;

    typedef struct packed {
        logic room;
        logic p_zero;
        logic gt;
        logic last;
        logic few;
        logic scan_end;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/cps_ctrl.sv -----
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer: load with insertion sort, then two-pointer scan, then result.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire cps_pkg::t_sts i_sts,
    output cps_pkg::t_cmd      o_cmd
);
    import cps_pkg::*;

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_FIN     = 3'd3;
    localparam logic [2:0] S_SC_RD   = 3'd4;
    localparam logic [2:0] S_SC_DIFF = 3'd5;
    localparam logic [2:0] S_SC_EVAL = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.room) n_state = S_INS_RD;
                    else if (i_in_last) n_state = S_FIN;
                end
            end
            S_INS_RD: begin
                o_cmd.ins_rd = 1'b1;
                if (!i_sts.p_zero) n_state = S_INS_CMP;
                else n_state = i_sts.last ? S_FIN : S_LOAD;
            end
            S_INS_CMP: begin
                o_cmd.ins_cmp = 1'b1;
                if (i_sts.gt) n_state = S_INS_RD;
                else n_state = i_sts.last ? S_FIN : S_LOAD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = i_sts.few ? S_OUT : S_SC_RD;
            end
            S_SC_RD: begin
                o_cmd.sc_rd = 1'b1;
                n_state = S_SC_DIFF;
            end
            S_SC_DIFF: begin
                o_cmd.sc_diff = 1'b1;
                n_state = S_SC_EVAL;
            end
            S_SC_EVAL: begin
                o_cmd.sc_eval = 1'b1;
                n_state = i_sts.scan_end ? S_OUT : S_SC_RD;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.out_ack = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else r_state <= n_state;
    end

endmodule

`default_nettype wire

// ----- rtl/cps_dp.sv -----
// ----------------------------------------------------------------------------
// cps_dp
// Value store, insertion shift path, scan pointers and best-pair registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_dp #(
    parameter int MAX_ITEMS = cps_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [cps_pkg::DATA_W-1:0]    i_elem,
    input  wire logic                          i_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [cps_pkg::DATA_W-1:0]    i_cfg_data,
    input  wire cps_pkg::t_cmd                 i_cmd,
    output cps_pkg::t_sts                      o_sts,
    output logic [cps_pkg::DATA_W-1:0]         o_lo,
    output logic [cps_pkg::DATA_W-1:0]         o_hi,
    output logic                               o_pv
);
    import cps_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [DATA_W-1:0] mem [MAX_ITEMS];

    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_p;
    logic [AW-1:0]       r_a;
    logic [AW-1:0]       r_b;
    logic [DATA_W-1:0]   r_val;
    logic                r_last;
    logic [DATA_W-1:0]   r_tgt;
    logic [DATA_W-1:0]   r_rd0;
    logic [DATA_W-1:0]   r_rd1;
    logic [DATA_W-1:0]   r_ca;
    logic [DATA_W-1:0]   r_cb;
    logic [DIFF_W-1:0]   r_diff;
    logic [DIFF_W-1:0]   r_best;
    logic                r_have;
    logic [DATA_W-1:0]   r_lo;
    logic [DATA_W-1:0]   r_hi;

    logic [AW-1:0]       addr0;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [DATA_W-1:0]   wdata;
    logic [SUM_W-1:0]    sum;
    logic [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]   absd;
    logic                upd;

    assign o_sts.room     = (r_count < CW'(MAX_ITEMS));
    assign o_sts.p_zero   = (r_p == '0);
    assign o_sts.gt       = ($signed(r_rd0) > $signed(r_val));
    assign o_sts.last     = r_last;
    assign o_sts.few      = (r_count < CW'(2));
    assign o_sts.scan_end = (r_diff == '0) || ((r_b - r_a) == AW'(1));

    assign sum  = {r_rd0[DATA_W-1], r_rd0} + {r_rd1[DATA_W-1], r_rd1};
    assign diff = {sum[SUM_W-1], sum} - {{2{r_tgt[DATA_W-1]}}, r_tgt};
    assign absd = r_diff[DIFF_W-1] ? (~r_diff + DIFF_W'(1)) : r_diff;
    assign upd  = !r_have || (absd < r_best);

    always_comb begin
        addr0 = r_a;
        we    = 1'b0;
        waddr = r_p;
        wdata = r_val;
        if (i_cmd.ins_rd) begin
            if (r_p == '0) we = 1'b1;
            else addr0 = r_p - AW'(1);
        end
        if (i_cmd.ins_cmp) begin
            we = 1'b1;
            if ($signed(r_rd0) > $signed(r_val)) wdata = r_rd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd0 <= mem[addr0];
        r_rd1 <= mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tgt   <= '0;
            r_have  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            if (i_cfg_we) r_tgt <= i_cfg_data;
            if (i_cmd.take) begin
                r_val  <= i_elem;
                r_last <= i_last;
                r_p    <= r_count[AW-1:0];
            end
            if (i_cmd.ins_rd && r_p == '0) r_count <= r_count + CW'(1);
            if (i_cmd.ins_cmp) begin
                if ($signed(r_rd0) > $signed(r_val)) r_p <= r_p - AW'(1);
                else r_count <= r_count + CW'(1);
            end
            if (i_cmd.fin) begin
                r_a     <= '0;
                r_b     <= AW'(r_count - CW'(1));
                r_have  <= 1'b0;
                r_count <= '0;
                if (r_count < CW'(2)) begin
                    o_lo <= '0;
                    o_hi <= '0;
                    o_pv <= 1'b0;
                end
            end
            if (i_cmd.sc_diff) begin
                r_diff <= diff;
                r_ca   <= r_rd0;
                r_cb   <= r_rd1;
            end
            if (i_cmd.sc_eval) begin
                if (upd) begin
                    r_have <= 1'b1;
                    r_best <= absd;
                    r_lo   <= r_ca;
                    r_hi   <= r_cb;
                end
                if (r_diff[DIFF_W-1]) r_a <= r_a + AW'(1);
                else r_b <= r_b - AW'(1);
                if (o_sts.scan_end) begin
                    o_lo <= upd ? r_ca : r_lo;
                    o_hi <= upd ? r_cb : r_hi;
                    o_pv <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/closest_pair_sum_search_top.sv -----
// ----------------------------------------------------------------------------
// closest_pair_sum_search_top
// Closest two-element sum to a target: sorted load, two-pointer scan.
//
// channel  dir  signals                         content
// s_axis   in   tvalid tready tdata tlast       element, last mark
// m_axis   out  tvalid tready tdata tuser       pair_low/pair_high, pair_valid
// cfg      in   i_cfg_valid o_cfg_ready data    target_sum
//
// Each value is insertion-sorted on arrival: once it is taken, the store
// reads one neighbor per step and shifts it up while it is greater, then
// writes the value in its place or at the head.
// After the last value, a start state sets up the scan; each scan step reads
// both ends, subtracts the target and keeps the best, at most n-1 steps.
// Reset clears the count and target; the store needs no clearing.
// Input is stalled while a value is inserted, and from the last value
// until the result request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_pair_sum_search_top #(
    parameter int MAX_ITEMS = cps_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [cps_pkg::DATA_W-1:0]      s_axis_tdata,  // [31:0] element
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [2*cps_pkg::DATA_W-1:0]         m_axis_tdata,  // [31:0] low, [63:32] high
    output logic                                 m_axis_tuser,  // [0] pair_valid
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cps_pkg::DATA_W-1:0]      i_cfg_data
);
    import cps_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {hi, lo};

    cps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cps_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_elem     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_lo       (lo),
        .o_hi       (hi),
        .o_pv       (m_axis_tuser)
    );

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid result with nonzero data");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        ($signed(m_axis_tdata[DATA_W-1:0]) <= $signed(m_axis_tdata[2*DATA_W-1:DATA_W])))
        else $error("pair out of order");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("no return to load");

endmodule

`default_nettype wire

// ----- test/tb_closest_pair_sum_search_top.sv -----
// ----------------------------------------------------------------------------
// tb_closest_pair_sum_search_top
// Streams signed value sets into the closest pair sum search, predicts the
// pair nearest the target by sorting and a two-pointer scan, and checks
// every result field in order. Target is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_closest_pair_sum_search_top;

    localparam int MAX_N  = cps_pkg::MAX_ITEMS_DEF;
    localparam int DW     = cps_pkg::DATA_W;
    localparam int LIMIT  = 3000000;

    typedef struct packed {
        logic [DW-1:0] element;
        logic          last;
    } t_item;

    typedef struct packed {
        logic [DW-1:0] pair_low;
        logic [DW-1:0] pair_high;
        logic          pair_valid;
    } t_pair;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [2*DW-1:0] m_axis_tdata;
    logic          m_axis_tuser;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [DW-1:0] i_cfg_data;

    closest_pair_sum_search_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    t_item       pending_items[$];
    t_pair       expected_pairs[$];
    logic [DW-1:0] held_values[$];
    logic signed [DW-1:0] target_sum;
    int          error_count;
    int          cycle_count;
    bit          calm;
    int          src_gap;
    int          snk_gap;
    int          queued_items;
    logic        s_axis_tready_q;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic t_pair closest_pair(input logic [DW-1:0] vals[$],
                                           input logic signed [DW-1:0] tgt);
        t_pair r;
        longint s[$];
        longint v, sum, delta, best_delta;
        int a, b, p;
        bit have;
        r = '0;
        have = 0;
        best_delta = 0;
        if (vals.size() < 2) return r;
        foreach (vals[k]) begin
            v = longint'($signed(vals[k]));
            p = s.size();
            while (p > 0 && s[p-1] > v) p--;
            s.insert(p, v);
        end
        a = 0;
        b = s.size() - 1;
        while (a < b) begin
            sum = s[a] + s[b];
            delta = sum - longint'(tgt);
            if (delta < 0) delta = -delta;
            if (!have || delta < best_delta) begin
                have = 1;
                best_delta = delta;
                r.pair_low = s[a][DW-1:0];
                r.pair_high = s[b][DW-1:0];
            end
            if (sum == longint'(tgt)) break;
            if (sum < longint'(tgt)) a++;
            else b--;
        end
        r.pair_valid = 1'b1;
        return r;
    endfunction

    // handshake as seen at the last rising edge
    always @(posedge i_clk) s_axis_tready_q <= s_axis_tready;

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    {s_axis_tdata, s_axis_tlast} <= pending_items.pop_front();
                    if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 13);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 13);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pair want;
        t_pair got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_values.size() < MAX_N)
                    held_values.insert(held_values.size(), s_axis_tdata);
                if (s_axis_tlast) begin
                    expected_pairs.insert(expected_pairs.size(),
                                          closest_pair(held_values, target_sum));
                    held_values.delete();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[DW-1:0], m_axis_tdata[2*DW-1:DW], m_axis_tuser};
                if (expected_pairs.size() == 0) begin
                    report_mismatch("unexpected result", got.pair_low, '0);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got.pair_valid !== want.pair_valid)
                        report_mismatch("pair_valid", DW'(got.pair_valid),
                                        DW'(want.pair_valid));
                    if (got.pair_low !== want.pair_low)
                        report_mismatch("pair_low", got.pair_low, want.pair_low);
                    if (got.pair_high !== want.pair_high)
                        report_mismatch("pair_high", got.pair_high, want.pair_high);
                end
            end
        end
        if (cycle_count > LIMIT) begin
            $display("tb_closest_pair_sum_search_top failed");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_value(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 40) - 20;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    task automatic queue_set(input int n, input int mode);
        t_item it;
        for (int k = 0; k < n; k++) begin
            it.element = rand_value(mode);
            it.last = (k == n - 1);
            pending_items.insert(pending_items.size(), it);
        end
        queued_items += n;
    endtask

    task automatic queue_fixed(input logic [DW-1:0] vals[$]);
        t_item it;
        foreach (vals[k]) begin
            it.element = vals[k];
            it.last = (k == vals.size() - 1);
            pending_items.insert(pending_items.size(), it);
        end
        queued_items += vals.size();
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_pairs.size() > 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [DW-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        target_sum = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [DW-1:0] targets[6];
        int len;
        error_count = 0;
        cycle_count = 0;
        calm = 0;
        src_gap = 0;
        snk_gap = 0;
        queued_items = 0;
        target_sum = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single value, exact hit, ties, extremes, overlong set
        queue_fixed('{32'd5});
        queue_fixed('{32'd3, 32'hFFFF_FFFD});
        queue_fixed('{32'd1, 32'd2, 32'd3, 32'd4});
        queue_fixed('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
        queue_fixed('{32'd9, 32'd7, 32'd1, 32'd3, 32'd3});
        queue_set(MAX_N + 3, 0);
        drain();

        targets = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd10, 32'hFFFF_FFF6, 32'h5555_AAAA, 32'd0};
        for (int ph = 0; ph < 6; ph++) begin
            write_target(targets[ph]);
            queue_fixed('{32'h7FFF_FFFF, 32'h8000_0000, 32'd0});
            queue_fixed('{32'd4, 32'd6});
            while (queued_items < 100 + 240 * (ph + 1)) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_N - 2, MAX_N + 2)
                                                   : $urandom_range(1, 12);
                queue_set(len, $urandom_range(0, 3));
            end
            if (ph == 5) calm = 1;
            drain();
        end

        if (error_count == 0) begin
            $display("tb_closest_pair_sum_search_top passed");
        end else begin
            $display("tb_closest_pair_sum_search_top failed");
        end
        $finish;
    end

endmodule

// ----- closest_pair_sum_search_top.f -----
rtl/cps_pkg.sv
rtl/cps_ctrl.sv
rtl/cps_dp.sv
rtl/closest_pair_sum_search_top.sv
test/tb_closest_pair_sum_search_top.sv
